@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every property is sampled on the rising
// edge of i_clk and is ignored while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that, once seen, must be followed by another one in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ipv6p_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 address text parser package
// Shared sizes and the record that hands a finished address from the
// character parser to the compression stage.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

    localparam int NUM_PIECES  = 8;
    localparam int PIECE_W     = 16;
    localparam int PIECE_IDX_W = 3;
    localparam int COUNT_W     = 4;
    localparam int TEXT_W      = 8;
    localparam int OUT_W       = NUM_PIECES * PIECE_W;

    typedef logic [NUM_PIECES-1:0][PIECE_W-1:0] t_piece_array;

    // Parser state right after the final character of an address.
    typedef struct packed {
        logic               failed;
        t_piece_array       pieces;
        logic [COUNT_W-1:0] next_piece;
        logic [COUNT_W-1:0] comp_idx;
        logic               comp_seen;
        logic               tail;
        logic [2:0]         oct_cnt;
        logic [7:0]         oct_val;
        logic               oct_started;
        logic               group_open;
        logic [PIECE_W-1:0] group_val;
    } t_fin;

endpackage

@@ rtl/ipv6p_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 address character parser
// Input register, running parse state updated once per character, and a
// hand-off register that holds the state left by the final character.
// ----------------------------------------------------------------------------
module ipv6p_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [ipv6p_pkg::TEXT_W-1:0] i_s_tdata,
    input  logic                        i_s_tlast,
    output logic                        o_fin_valid,
    input  logic                        i_fin_ready,
    output ipv6p_pkg::t_fin             o_fin
);
    import ipv6p_pkg::*;

    typedef enum logic [1:0] {
        PH_START,
        PH_LEAD_COLON,
        PH_TOKEN,
        PH_GROUP
    } t_phase;

    localparam logic [TEXT_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [TEXT_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [TEXT_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [TEXT_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [TEXT_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [TEXT_W-1:0] CHAR_LO_F  = 8'h66;
    localparam logic [TEXT_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [TEXT_W-1:0] CHAR_UP_F  = 8'h46;
    localparam logic [11:0]       DEC_LIMIT  = 12'd255;
    localparam logic [8:0]        DEC_SAT    = 9'd256;
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(NUM_PIECES);

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_decode(input logic [TEXT_W-1:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            res = {1'b1, c[3:0]};
        end else if ((c >= CHAR_LO_A && c <= CHAR_LO_F) ||
                     (c >= CHAR_UP_A && c <= CHAR_UP_F)) begin
            res = {1'b1, c[3:0] + 4'd9};
        end
        return res;
    endfunction

    logic                r_in_valid;
    logic [TEXT_W-1:0]   r_in_byte;
    logic                r_in_last;
    logic                r_fin_valid;
    t_fin                r_fin;

    t_piece_array        r_pieces,      n_pieces;
    logic [COUNT_W-1:0]  r_next_piece,  n_next_piece;
    logic [COUNT_W-1:0]  r_comp_idx,    n_comp_idx;
    logic                r_comp_seen,   n_comp_seen;
    logic [PIECE_W-1:0]  r_grp_val,     n_grp_val;
    logic [2:0]          r_grp_cnt,     n_grp_cnt;
    logic [8:0]          r_grp_dec,     n_grp_dec;
    logic                r_grp_dec_ok,  n_grp_dec_ok;
    t_phase              r_phase,       n_phase;
    logic                r_tail,        n_tail;
    logic [2:0]          r_oct_cnt,     n_oct_cnt;
    logic [7:0]          r_oct_val,     n_oct_val;
    logic                r_oct_started, n_oct_started;
    logic                r_failed,      n_failed;

    logic                in_adv;
    logic                fin_free;
    logic                s_ready;
    logic [4:0]          hx;
    logic                is_digit;
    logic                is_dec_hex;
    logic [11:0]         grp_dec_next;
    logic [11:0]         oct_next;
    logic [2:0]          oct_inc;
    logic                run_token;
    logic                do_put;
    logic                do_store;
    logic [7:0]          put_val;
    t_fin                n_fin;

    assign fin_free    = !r_fin_valid || i_fin_ready;
    // A final character may only move on when the hand-off register frees up.
    assign in_adv      = r_in_valid && (!r_in_last || fin_free);
    assign s_ready     = !r_in_valid || in_adv;
    assign o_s_tready  = s_ready;
    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    assign hx           = hex_decode(r_in_byte);
    assign is_digit     = (r_in_byte >= CHAR_ZERO) && (r_in_byte <= CHAR_NINE);
    assign is_dec_hex   = hx[3:0] <= 4'd9;
    assign grp_dec_next = {3'b0, r_grp_dec} * 12'd10
                        + {8'b0, (is_dec_hex ? hx[3:0] : 4'd0)};
    assign oct_next     = {4'b0, r_oct_val} * 12'd10 + {8'b0, r_in_byte[3:0]};
    assign oct_inc      = r_oct_cnt + 3'd1;

    always_comb begin
        n_pieces      = r_pieces;
        n_next_piece  = r_next_piece;
        n_comp_idx    = r_comp_idx;
        n_comp_seen   = r_comp_seen;
        n_grp_val     = r_grp_val;
        n_grp_cnt     = r_grp_cnt;
        n_grp_dec     = r_grp_dec;
        n_grp_dec_ok  = r_grp_dec_ok;
        n_phase       = r_phase;
        n_tail        = r_tail;
        n_oct_cnt     = r_oct_cnt;
        n_oct_val     = r_oct_val;
        n_oct_started = r_oct_started;
        n_failed      = r_failed;
        run_token     = 1'b0;
        do_put        = 1'b0;
        do_store      = 1'b0;
        put_val       = r_grp_dec[7:0];

        if (!r_failed) begin
            if (r_tail) begin
                if (is_digit) begin
                    if (!r_oct_started) begin
                        n_oct_val     = {4'b0, r_in_byte[3:0]};
                        n_oct_started = 1'b1;
                    end else if (r_oct_val == 8'd0) begin
                        n_failed = 1'b1;
                    end else if (oct_next > DEC_LIMIT) begin
                        n_failed = 1'b1;
                    end else begin
                        n_oct_val = oct_next[7:0];
                    end
                end else if (r_in_byte == CHAR_DOT) begin
                    if (!r_oct_started) begin
                        n_failed = 1'b1;
                    end else begin
                        do_put  = 1'b1;
                        put_val = r_oct_val;
                        if (oct_inc >= 3'd4) begin
                            n_failed = 1'b1;
                        end else begin
                            n_oct_started = 1'b0;
                            n_oct_val     = 8'd0;
                        end
                    end
                end else begin
                    n_failed = 1'b1;
                end
            end else begin
                case (r_phase)
                    PH_START: begin
                        if (r_in_byte == CHAR_COLON) begin
                            if (r_in_last) begin
                                n_failed = 1'b1;
                            end else begin
                                n_phase = PH_LEAD_COLON;
                            end
                        end else begin
                            run_token = 1'b1;
                        end
                    end
                    PH_LEAD_COLON: begin
                        if (r_in_byte != CHAR_COLON) begin
                            n_failed = 1'b1;
                        end else begin
                            n_next_piece = COUNT_W'(1);
                            n_comp_idx   = COUNT_W'(1);
                            n_comp_seen  = 1'b1;
                            n_phase      = PH_TOKEN;
                        end
                    end
                    PH_TOKEN: begin
                        run_token = 1'b1;
                    end
                    PH_GROUP: begin
                        if (hx[4]) begin
                            if (r_grp_cnt >= 3'd4) begin
                                n_failed = 1'b1;
                            end else begin
                                // A leading zero or a letter rules out a decimal octet.
                                n_grp_dec_ok = r_grp_dec_ok && is_dec_hex && (r_grp_dec != 9'd0);
                                n_grp_dec    = (grp_dec_next > DEC_LIMIT) ? DEC_SAT
                                                                          : grp_dec_next[8:0];
                                n_grp_val    = {r_grp_val[PIECE_W-5:0], hx[3:0]};
                                n_grp_cnt    = r_grp_cnt + 3'd1;
                            end
                        end else if (r_in_byte == CHAR_DOT) begin
                            if (r_next_piece > COUNT_W'(6) || !r_grp_dec_ok ||
                                {3'b0, r_grp_dec} > DEC_LIMIT) begin
                                n_failed = 1'b1;
                            end else begin
                                do_put        = 1'b1;
                                put_val       = r_grp_dec[7:0];
                                n_tail        = 1'b1;
                                n_oct_started = 1'b0;
                                n_oct_val     = 8'd0;
                            end
                        end else if (r_in_byte == CHAR_COLON) begin
                            if (r_in_last) begin
                                n_failed = 1'b1;
                            end else begin
                                do_store = 1'b1;
                                n_phase  = PH_TOKEN;
                            end
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    default: begin
                        n_failed = 1'b1;
                    end
                endcase

                if (run_token) begin
                    n_phase = PH_TOKEN;
                    if (r_next_piece >= FULL_COUNT) begin
                        n_failed = 1'b1;
                    end else if (r_in_byte == CHAR_COLON) begin
                        if (r_comp_seen) begin
                            n_failed = 1'b1;
                        end else begin
                            n_next_piece = r_next_piece + COUNT_W'(1);
                            n_comp_idx   = r_next_piece + COUNT_W'(1);
                            n_comp_seen  = 1'b1;
                        end
                    end else if (!hx[4]) begin
                        n_failed = 1'b1;
                    end else begin
                        n_grp_val    = {{(PIECE_W-4){1'b0}}, hx[3:0]};
                        n_grp_cnt    = 3'd1;
                        n_grp_dec_ok = is_dec_hex;
                        n_grp_dec    = is_dec_hex ? {5'b0, hx[3:0]} : 9'd0;
                        n_phase      = PH_GROUP;
                    end
                end
            end
        end

        // Octets fill the current piece high byte first.
        if (do_put) begin
            n_pieces[r_next_piece[PIECE_IDX_W-1:0]] =
                {r_pieces[r_next_piece[PIECE_IDX_W-1:0]][7:0], put_val};
            n_oct_cnt = oct_inc;
            if (oct_inc == 3'd2 || oct_inc == 3'd4) begin
                n_next_piece = r_next_piece + COUNT_W'(1);
            end
        end
        if (do_store) begin
            n_pieces[r_next_piece[PIECE_IDX_W-1:0]] = r_grp_val;
            n_next_piece = r_next_piece + COUNT_W'(1);
            n_grp_val    = '0;
            n_grp_cnt    = 3'd0;
            n_grp_dec    = 9'd0;
            n_grp_dec_ok = 1'b1;
        end
    end

    always_comb begin
        n_fin.failed      = n_failed;
        n_fin.pieces      = n_pieces;
        n_fin.next_piece  = n_next_piece;
        n_fin.comp_idx    = n_comp_idx;
        n_fin.comp_seen   = n_comp_seen;
        n_fin.tail        = n_tail;
        n_fin.oct_cnt     = n_oct_cnt;
        n_fin.oct_val     = n_oct_val;
        n_fin.oct_started = n_oct_started;
        n_fin.group_open  = (n_phase == PH_GROUP);
        n_fin.group_val   = n_grp_val;
    end

    always_ff @(posedge i_clk) begin
        // The final character of an address returns the parse state to its start.
        if (!i_rst_n || (in_adv && r_in_last)) begin
            r_pieces      <= '0;
            r_next_piece  <= '0;
            r_comp_idx    <= '0;
            r_comp_seen   <= 1'b0;
            r_grp_val     <= '0;
            r_grp_cnt     <= 3'd0;
            r_grp_dec     <= 9'd0;
            r_grp_dec_ok  <= 1'b1;
            r_phase       <= PH_START;
            r_tail        <= 1'b0;
            r_oct_cnt     <= 3'd0;
            r_oct_val     <= 8'd0;
            r_oct_started <= 1'b0;
            r_failed      <= 1'b0;
        end else if (in_adv) begin
            r_pieces      <= n_pieces;
            r_next_piece  <= n_next_piece;
            r_comp_idx    <= n_comp_idx;
            r_comp_seen   <= n_comp_seen;
            r_grp_val     <= n_grp_val;
            r_grp_cnt     <= n_grp_cnt;
            r_grp_dec     <= n_grp_dec;
            r_grp_dec_ok  <= n_grp_dec_ok;
            r_phase       <= n_phase;
            r_tail        <= n_tail;
            r_oct_cnt     <= n_oct_cnt;
            r_oct_val     <= n_oct_val;
            r_oct_started <= n_oct_started;
            r_failed      <= n_failed;
        end

        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            if (s_ready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (fin_free) begin
                r_fin_valid <= in_adv && r_in_last;
            end
        end

        if (s_ready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (fin_free && in_adv && r_in_last) begin
            r_fin <= n_fin;
        end
    end

endmodule

@@ rtl/ipv6p_compress.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 address completion and compression stage
// Closes the open group or dotted tail, checks the piece count, moves the
// pieces after a "::" to the end of the address and registers the result.
// ----------------------------------------------------------------------------
module ipv6p_compress (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fin_valid,
    output logic                    o_ready,
    input  ipv6p_pkg::t_fin         i_fin,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic                    o_status,
    output ipv6p_pkg::t_piece_array o_pieces
);
    import ipv6p_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(NUM_PIECES);

    logic                   r_out_valid;
    logic                   r_status;
    t_piece_array           r_pieces;

    t_piece_array           p;
    t_piece_array           shifted;
    logic [COUNT_W-1:0]     npi;
    logic [2:0]             oct_cnt;
    logic [PIECE_IDX_W-1:0] src;
    logic                   fail;
    logic                   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_ready    = out_free;
    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_status;
    assign o_pieces   = r_pieces;

    always_comb begin
        p       = i_fin.pieces;
        npi     = i_fin.next_piece;
        fail    = i_fin.failed;
        oct_cnt = i_fin.oct_cnt;
        src     = '0;

        if (i_fin.tail) begin
            if (i_fin.oct_started) begin
                p[npi[PIECE_IDX_W-1:0]] = {i_fin.pieces[npi[PIECE_IDX_W-1:0]][7:0],
                                           i_fin.oct_val};
                oct_cnt = i_fin.oct_cnt + 3'd1;
                if (oct_cnt == 3'd2 || oct_cnt == 3'd4) begin
                    npi = i_fin.next_piece + COUNT_W'(1);
                end
            end
            if (oct_cnt != 3'd4) begin
                fail = 1'b1;
            end
        end else if (i_fin.group_open) begin
            p[npi[PIECE_IDX_W-1:0]] = i_fin.group_val;
            npi = i_fin.next_piece + COUNT_W'(1);
        end

        if (!i_fin.comp_seen && npi != FULL_COUNT) begin
            fail = 1'b1;
        end

        // Pieces from the compression point on slide right by the number of
        // missing pieces; the gap they leave reads as zero.
        for (int i = 0; i < NUM_PIECES; i++) begin
            src = PIECE_IDX_W'(i) + npi[PIECE_IDX_W-1:0];
            if (i_fin.comp_seen && COUNT_W'(i) >= i_fin.comp_idx) begin
                if ((COUNT_W+1)'(i) + {1'b0, npi} >=
                    (COUNT_W+1)'(NUM_PIECES) + {1'b0, i_fin.comp_idx}) begin
                    shifted[i] = p[src];
                end else begin
                    shifted[i] = '0;
                end
            end else begin
                shifted[i] = p[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_fin_valid;
        end

        if (out_free && i_fin_valid) begin
            r_status <= fail;
            r_pieces <= fail ? '0 : shifted;
        end
    end

endmodule

@@ rtl/ipv6_address_text_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 address text parser
// Parses the bracket-free text of an IPv6 address, one character per item,
// into eight 16-bit pieces with a pass or fail status.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                  Items
//  s_axis    in         tdata[7:0] character, tlast end of text  one per character
//  m_axis    out        tdata 8 x 16-bit pieces, tuser status    one per address
//
//  One character is taken every cycle while no final character waits; the
//  parse state is updated in a single pass between the input register and
//  the hand-off register. A result moves from the hand-off register to the
//  compression stage output register after its final character is taken.
//  Reset is synchronous and clears the parse state directly.
//  Characters keep flowing while a result waits; a final character waits
//  only while both the hand-off and output registers are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv6_address_text_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [7:0] text_byte
    input  logic [ipv6p_pkg::TEXT_W-1:0]  i_s_tdata,
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [15:0] piece_0, [31:16] piece_1, ... [127:112] piece_7
    output logic [ipv6p_pkg::OUT_W-1:0]   o_m_tdata,
    // [0] status
    output logic                          o_m_tuser
);
    import ipv6p_pkg::*;

    logic         fin_valid;
    logic         fin_ready;
    t_fin         fin;
    t_piece_array out_pieces;

    ipv6p_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_fin_valid (fin_valid),
        .i_fin_ready (fin_ready),
        .o_fin       (fin)
    );

    ipv6p_compress u_compress (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .o_ready     (fin_ready),
        .i_fin       (fin),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_status    (o_m_tuser),
        .o_pieces    (out_pieces)
    );

    assign o_m_tdata = out_pieces;

    // A failed address carries no pieces.
    `ASSERT_ALWAYS(a_fail_zero, !(o_m_tvalid && o_m_tuser) || (o_m_tdata == '0), "failed result with nonzero pieces")
    // With the output register empty nothing downstream can hold back a character.
    `ASSERT_ALWAYS(a_ready_when_empty, o_m_tvalid || o_s_tready, "input stalled with empty output")
    // A finished address waiting for the compression stage must not change or vanish.
    `ASSERT_NEXT(a_fin_hold, fin_valid && !fin_ready, fin_valid && $stable(fin), "hand-off item lost while stalled")

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IPv6 address text parser
// Streams address text one character per item and predicts every parsed
// address in a behavioral model of the parser. A clocked driver and monitor
// run the two stream ports with random idling and back-pressure. The
// monitor checks status and all eight pieces of each result in order.
// ----------------------------------------------------------------------------
module tb_top;

    import ipv6p_pkg::*;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam int         NO_HEX   = 16;
    localparam int         RX_HOLD_CYCLES = 300;
    localparam string      HEX_CHARS = "0123456789abcdefABCDEF";
    localparam string      NASTY_CHARS = ":.0a9fgx";

    typedef enum logic [1:0] {
        AT_START,
        AFTER_LEAD_COLON,
        AT_TOKEN,
        IN_GROUP
    } t_parse_pos;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    typedef struct packed {
        logic         status;
        t_piece_array pieces;
    } t_parsed_addr;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [TEXT_W-1:0]   i_s_tdata = '0;
    logic                i_s_tlast = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [OUT_W-1:0]    o_m_tdata;
    logic                o_m_tuser;

    ipv6_address_text_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_text_char   char_stream[$];
    t_parsed_addr addr_expect[$];
    logic [7:0]   addr_text[$];
    int           chars_taken = 0;
    int           offer_idx = 0;
    int           error_count = 0;
    int           src_idle_pct = 0;
    int           snk_stall_pct = 0;
    int           hold_request = 0;
    int           hold_served = 0;
    int           rx_hold_left = 0;

    // ------------------------------------------------------------------
    // Behavioral parser state
    // ------------------------------------------------------------------
    t_piece_array addr_pieces;
    logic [3:0]   next_idx;
    logic [3:0]   comp_idx;
    logic         comp_seen;
    logic [15:0]  grp_hex;
    logic [2:0]   grp_cnt;
    logic [8:0]   grp_dec;
    logic         grp_dec_ok;
    t_parse_pos   pos;
    logic         in_tail;
    logic [2:0]   oct_cnt;
    logic [8:0]   oct_val;
    logic         oct_started;
    logic         failed;

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return NO_HEX;
    endfunction

    task automatic clear_parser();
        addr_pieces = '0;
        next_idx    = '0;
        comp_idx    = '0;
        comp_seen   = 1'b0;
        grp_hex     = '0;
        grp_cnt     = '0;
        grp_dec     = '0;
        grp_dec_ok  = 1'b1;
        pos         = AT_START;
        in_tail     = 1'b0;
        oct_cnt     = '0;
        oct_val     = '0;
        oct_started = 1'b0;
        failed      = 1'b0;
    endtask

    // Octets are shifted into the current piece; every second one moves on.
    task automatic store_octet(logic [8:0] v);
        int idx;
        idx = int'(next_idx) & 7;
        addr_pieces[idx] = {addr_pieces[idx][7:0], v[7:0]};
        oct_cnt = oct_cnt + 1'b1;
        if (oct_cnt == 3'd2 || oct_cnt == 3'd4) next_idx = next_idx + 1'b1;
    endtask

    task automatic store_group();
        addr_pieces[int'(next_idx) & 7] = grp_hex;
        next_idx   = next_idx + 1'b1;
        grp_hex    = '0;
        grp_cnt    = '0;
        grp_dec    = '0;
        grp_dec_ok = 1'b1;
    endtask

    task automatic token_char(logic [7:0] c);
        int h;
        h = hex_digit(c);
        if (next_idx >= 4'd8) begin
            failed = 1'b1;
            return;
        end
        if (c == CH_COLON) begin
            if (comp_seen) begin
                failed = 1'b1;
                return;
            end
            next_idx  = next_idx + 1'b1;
            comp_idx  = next_idx;
            comp_seen = 1'b1;
            return;
        end
        if (h == NO_HEX) begin
            failed = 1'b1;
            return;
        end
        grp_hex    = 16'(h);
        grp_cnt    = 3'd1;
        grp_dec_ok = (h <= 9);
        grp_dec    = (h <= 9) ? 9'(h) : 9'd0;
        pos        = IN_GROUP;
    endtask

    // A group is tracked both as hex and as a candidate decimal octet,
    // since a '.' may turn it into the first octet of a dotted tail.
    task automatic group_char(logic [7:0] c, logic last);
        int h;
        int dv;
        h = hex_digit(c);
        if (h != NO_HEX) begin
            if (grp_cnt >= 3'd4) begin
                failed = 1'b1;
                return;
            end
            if (h > 9) grp_dec_ok = 1'b0;
            if (grp_dec == 9'd0) grp_dec_ok = 1'b0;
            dv = int'(grp_dec) * 10 + ((h <= 9) ? h : 0);
            grp_dec = (dv > 255) ? 9'd256 : 9'(dv);
            grp_hex = {grp_hex[11:0], 4'(h)};
            grp_cnt = grp_cnt + 1'b1;
            return;
        end
        if (c == CH_DOT) begin
            if (next_idx > 4'd6 || !grp_dec_ok || grp_dec > 9'd255) begin
                failed = 1'b1;
                return;
            end
            store_octet(grp_dec);
            in_tail     = 1'b1;
            oct_started = 1'b0;
            oct_val     = '0;
            return;
        end
        if (c == CH_COLON) begin
            if (last) begin
                failed = 1'b1;
                return;
            end
            store_group();
            pos = AT_TOKEN;
            return;
        end
        failed = 1'b1;
    endtask

    task automatic tail_char(logic [7:0] c);
        int v;
        if (c >= "0" && c <= "9") begin
            if (!oct_started) begin
                oct_val     = 9'(c - CH_ZERO);
                oct_started = 1'b1;
            end else if (oct_val == 9'd0) begin
                failed = 1'b1;
            end else begin
                v = int'(oct_val) * 10 + int'(c - CH_ZERO);
                if (v > 255) begin
                    failed = 1'b1;
                    return;
                end
                oct_val = 9'(v);
            end
            return;
        end
        if (c == CH_DOT) begin
            if (!oct_started) begin
                failed = 1'b1;
                return;
            end
            store_octet(oct_val);
            if (oct_cnt >= 3'd4) begin
                failed = 1'b1;
                return;
            end
            oct_started = 1'b0;
            oct_val     = '0;
            return;
        end
        failed = 1'b1;
    endtask

    task automatic finish_address();
        int         swaps;
        int         i;
        int         j;
        logic [15:0] t;
        if (in_tail) begin
            if (oct_started) store_octet(oct_val);
            if (oct_cnt != 3'd4) begin
                failed = 1'b1;
                return;
            end
        end else if (pos == IN_GROUP) begin
            store_group();
        end
        if (comp_seen) begin
            // Move the pieces after the "::" to the end, swapping from the top.
            swaps = int'(next_idx) - int'(comp_idx);
            i = 7;
            while (i != 0 && swaps > 0) begin
                j = (int'(comp_idx) + swaps - 1) & 7;
                t = addr_pieces[j];
                addr_pieces[j] = addr_pieces[i];
                addr_pieces[i] = t;
                swaps--;
                i--;
            end
        end else if (next_idx != 4'd8) begin
            failed = 1'b1;
        end
    endtask

    task automatic parse_char(logic [7:0] c, logic last);
        t_parsed_addr res;
        if (!failed) begin
            if (in_tail) begin
                tail_char(c);
            end else begin
                case (pos)
                    AT_START: begin
                        if (c == CH_COLON) begin
                            if (last) failed = 1'b1;
                            else pos = AFTER_LEAD_COLON;
                        end else begin
                            pos = AT_TOKEN;
                            token_char(c);
                        end
                    end
                    AFTER_LEAD_COLON: begin
                        if (c != CH_COLON) begin
                            failed = 1'b1;
                        end else begin
                            next_idx  = 4'd1;
                            comp_idx  = 4'd1;
                            comp_seen = 1'b1;
                            pos       = AT_TOKEN;
                        end
                    end
                    AT_TOKEN: token_char(c);
                    default: group_char(c, last);
                endcase
            end
        end
        if (last) begin
            if (!failed) finish_address();
            res.status = failed;
            res.pieces = failed ? '0 : addr_pieces;
            addr_expect.push_back(res);
            clear_parser();
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && chars_taken == offer_idx) begin
            // The offered item has not been taken yet, so it stays put.
        end else if (chars_taken < char_stream.size() &&
                     $urandom_range(99) >= src_idle_pct) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= char_stream[chars_taken].ch;
            i_s_tlast  <= char_stream[chars_taken].last;
            offer_idx  <= chars_taken;
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (hold_request != hold_served) begin
            hold_served  <= hold_request;
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_parsed_addr want;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                parse_char(i_s_tdata, i_s_tlast);
                chars_taken <= chars_taken + 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (addr_expect.size() == 0) begin
                    $display("%0t: unexpected result: status %0b pieces %h",
                             $time, o_m_tuser, o_m_tdata);
                    error_count++;
                end else begin
                    want = addr_expect.pop_front();
                    if (o_m_tuser !== want.status) begin
                        $display("%0t: status mismatch: expected %0b, got %0b",
                                 $time, want.status, o_m_tuser);
                        error_count++;
                    end
                    for (int k = 0; k < NUM_PIECES; k++) begin
                        if (o_m_tdata[k*PIECE_W +: PIECE_W] !== want.pieces[k]) begin
                            $display("%0t: piece %0d mismatch: expected %h, got %h",
                                     $time, k, want.pieces[k],
                                     o_m_tdata[k*PIECE_W +: PIECE_W]);
                            error_count++;
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_address();
        t_text_char item;
        for (int i = 0; i < addr_text.size(); i++) begin
            item.ch   = addr_text[i];
            item.last = (i == addr_text.size() - 1);
            char_stream.push_back(item);
        end
        addr_text.delete();
    endtask

    task automatic push_string(string s);
        for (int i = 0; i < s.len(); i++) addr_text.push_back(s[i]);
        push_address();
    endtask

    task automatic add_hex_group();
        int len;
        len = ($urandom_range(99) < 3) ? 5 : $urandom_range(4, 1);
        repeat (len) addr_text.push_back(HEX_CHARS[$urandom_range(21)]);
    endtask

    task automatic add_octet();
        int v;
        logic [7:0] digits[$];
        v = ($urandom_range(99) < 90) ? $urandom_range(255) : $urandom_range(999);
        if ($urandom_range(99) < 3) addr_text.push_back(CH_ZERO);
        do begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) addr_text.push_back(digits[i]);
    endtask

    task automatic add_ipv4_tail();
        for (int i = 0; i < 4; i++) begin
            if (i > 0) addr_text.push_back(CH_DOT);
            add_octet();
        end
    endtask

    function automatic logic [7:0] pick_bad_char();
        if ($urandom_range(1) == 0) return NASTY_CHARS[$urandom_range(7)];
        return 8'($urandom_range(255));
    endfunction

    task automatic mutate_text();
        int at;
        at = $urandom_range(addr_text.size() - 1);
        case ($urandom_range(3))
            0: addr_text[at] = pick_bad_char();
            1: addr_text.insert(at, pick_bad_char());
            2: if (addr_text.size() > 1) addr_text.delete(at);
            default: while (addr_text.size() > at + 1) void'(addr_text.pop_back());
        endcase
    endtask

    // Mostly well-formed addresses with random content, some broken ones
    // and a little plain noise.
    task automatic build_address();
        bit use_comp;
        bit use_tail;
        int npieces;
        int ntok;
        int gap_at;
        addr_text.delete();
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(8, 1)) addr_text.push_back(8'($urandom_range(255)));
            return;
        end
        use_comp = ($urandom_range(99) < 45);
        use_tail = ($urandom_range(99) < 30);
        if (use_comp) npieces = ($urandom_range(99) < 3) ? 8 : $urandom_range(7, 0);
        else npieces = ($urandom_range(99) < 90) ? 8 : $urandom_range(9, 6);
        if (npieces < 2) use_tail = 1'b0;
        ntok = use_tail ? npieces - 1 : npieces;
        gap_at = $urandom_range(ntok, 0);
        for (int t = 0; t < ntok; t++) begin
            if (use_comp && t == gap_at) begin
                addr_text.push_back(CH_COLON);
                addr_text.push_back(CH_COLON);
            end else if (t > 0) begin
                addr_text.push_back(CH_COLON);
            end
            if (use_tail && t == ntok - 1) add_ipv4_tail();
            else add_hex_group();
        end
        if (use_comp && gap_at == ntok) begin
            addr_text.push_back(CH_COLON);
            addr_text.push_back(CH_COLON);
        end
        if (addr_text.size() == 0) addr_text.push_back(HEX_CHARS[$urandom_range(21)]);
        if ($urandom_range(99) < 20) mutate_text();
    endtask

    task automatic wait_drained();
        while (chars_taken < char_stream.size() || addr_expect.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int src_pct, int snk_pct, int nchars);
        int base;
        @(negedge i_clk);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        base = char_stream.size();
        while (char_stream.size() - base < nchars) begin
            build_address();
            push_address();
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        push_string("::");
        push_string("::1");
        push_string("1::");
        push_string("ffff:FFFF:abcd:ABCD:0:9:10:fFfF");
        push_string("1:2:3:4:5:6:7:8");
        push_string(":1");
        push_string(":");
        push_string("1:");
        push_string("1::2::3");
        push_string("1:2:3:4:5:6:7:8:9");
        push_string("1:2:3:4:5:6:7:8::");
        push_string("12345::");
        push_string("::ffff:192.168.0.255");
        push_string("1:2:3:4:5:6:0.0.0.0");
        push_string("1:2:3:4:5:6:7:1.2.3.4");
        push_string("::256.1.1.1");
        push_string("::1.256.1.1");
        push_string("::01.1.1.1");
        push_string("::1.02.3.4");
        push_string("::1.2.3");
        push_string("::1.2.3.4.5");
        push_string("::1.2.3.a");
        push_string("::1.2.3:4");
        push_string("::a.1.2.3");
        push_string("1:2:3");
        push_string("g::x:1:2:3:4:5");
        addr_text.push_back(8'h00);
        push_address();
        addr_text.push_back(8'hff);
        push_address();
        wait_drained();

        run_phase(0, 0, 200);
        run_phase(83, 0, 200);
        run_phase(0, 83, 200);
        run_phase(27, 27, 200);

        // Long receiver hold-off while short addresses keep arriving, so the
        // block fills up and stalls its input.
        @(negedge i_clk);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_request  = hold_request + 1;
        repeat (40) push_string("::");
        repeat (10) begin
            build_address();
            push_address();
        end
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (error_count == 0 && addr_expect.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ipv6p_pkg.sv
rtl/ipv6p_parse.sv
rtl/ipv6p_compress.sv
rtl/ipv6_address_text_parser.sv
sim/tb_top.sv
